@@ hw/rtl/samn_pkg.sv @@
// Shared widths, codes and control types for the signed ADC mean normalizer.
package samn_pkg;

   localparam int SMP_W      = 10;  // converter sample
   localparam int SUM_W      = 24;  // signed accumulator
   localparam int MEAN_W     = 11;  // signed mean
   localparam int ZERO_W     = 11;  // signed zero offset
   localparam int GAIN_W     = 22;  // signed Q.20 gain
   localparam int SPEED_W    = 16;  // signed Q1.15 speed
   localparam int MAG_W      = 11;  // magnitude of (mean - zero)
   localparam int PROD_W     = 35;  // signed product, Q.20
   localparam int FRAC_DROP  = 5;   // Q.20 down to Q1.15
   localparam int STEP_W     = 5;   // serial step counter
   localparam int SKIP_W     = 5;   // sample skip counter
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 22;

   localparam logic [MEAN_W-2:0] MEAN_MAX = 10'd1023;

   localparam int SETTLE_SKIP_DEF = 3;
   localparam int START_SKIP_DEF  = 30;
   localparam int COUNT_MAX_DEF   = 4095;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_LEFT_ZERO_POS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_ZERO_NEG  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_ZERO_POS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_ZERO_NEG = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_GAIN_POS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_GAIN_NEG  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_GAIN_POS = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_GAIN_NEG = 3'd7;

   // sequencer to channel datapath
   typedef struct packed {
      logic load;       // snapshot sum and count for a tick
      logic clear;      // zero sum and count
      logic div_step;   // one quotient bit
      logic mean_step;  // saturate mean, pick side, set up multiply
      logic mul_step;   // one multiplier bit
      logic fin_step;   // scale and saturate speed
   } samn_ctrl_type;

endpackage

@@ hw/rtl/samn_channel.sv @@
// One channel: accumulator and count, bit-serial divider and shift-add multiplier.
module samn_channel import samn_pkg::*; #(
   parameter int COUNT_MAX = COUNT_MAX_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  samn_ctrl_type              ctrl,
   input  logic                       acc_en,
   input  logic [SMP_W-1:0]           sample,
   input  logic                       reverse,
   input  logic signed [ZERO_W-1:0]   zero_pos,
   input  logic signed [ZERO_W-1:0]   zero_neg,
   input  logic signed [GAIN_W-1:0]   gain_pos,
   input  logic signed [GAIN_W-1:0]   gain_neg,
   output logic signed [MEAN_W-1:0]   mean,
   output logic signed [SPEED_W-1:0]  speed,
   output logic                       empty
);

   localparam int CNT_W = $clog2(COUNT_MAX + 1);
   localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(COUNT_MAX);
   localparam int SH_W = PROD_W - FRAC_DROP;

   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic signed [SUM_W:0]     smp_ext, delta, sum_wide;

   logic [SUM_W-1:0]          quo_ff;
   logic [CNT_W-1:0]          rem_ff;
   logic [CNT_W-1:0]          dvs_ff;
   logic                      neg_ff;
   logic                      empty_ff;
   logic [CNT_W:0]            rem_shift;
   logic [CNT_W+1:0]          trial;
   logic                      qbit;
   logic [SUM_W-1:0]          sum_mag;

   logic [MEAN_W-2:0]         mag_sat;
   logic signed [MEAN_W-1:0]  mean_val;
   logic                      use_pos;
   logic signed [ZERO_W-1:0]  zsel;
   logic signed [MAG_W:0]     diff, diff_neg;
   logic signed [GAIN_W:0]    gsel;

   logic signed [MEAN_W-1:0]  mean_ff;
   logic [MAG_W-1:0]          mplier_ff;
   logic                      dneg_ff;
   logic signed [PROD_W-1:0]  mcand_ff;
   logic signed [PROD_W-1:0]  acc_ff;
   logic signed [PROD_W-1:0]  prod;
   logic signed [SH_W-1:0]    shr;
   logic [SH_W-SPEED_W:0]     shr_hi;
   logic signed [SPEED_W-1:0] speed_sat;
   logic signed [SPEED_W-1:0] speed_ff;

   // accumulate with saturation
   always_comb begin
      smp_ext  = $signed({{(SUM_W + 1 - SMP_W){1'b0}}, sample});
      delta    = reverse ? -smp_ext : smp_ext;
      sum_wide = $signed({sum_ff[SUM_W-1], sum_ff}) + delta;
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      if (ctrl.clear) begin
         sum_in = '0;
         cnt_in = '0;
      end else if (acc_en) begin
         if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_in = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                     : {1'b0, {(SUM_W-1){1'b1}}};
         end else begin
            sum_in = sum_wide[SUM_W-1:0];
         end
         if (cnt_ff != CNT_TOP) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   // restoring divide on magnitudes, one quotient bit a step
   always_comb begin
      sum_mag   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : sum_ff;
      rem_shift = {rem_ff, quo_ff[SUM_W-1]};
      trial     = {1'b0, rem_shift} - {2'b00, dvs_ff};
      qbit      = !trial[CNT_W+1];
   end

   // mean, side select and multiply setup
   always_comb begin
      mag_sat  = (|quo_ff[SUM_W-1:MEAN_W-1]) ? MEAN_MAX : quo_ff[MEAN_W-2:0];
      if (empty_ff) begin
         mean_val = '0;
      end else if (neg_ff) begin
         mean_val = -$signed({1'b0, mag_sat});
      end else begin
         mean_val = $signed({1'b0, mag_sat});
      end
      use_pos  = !empty_ff && !neg_ff && (mag_sat != '0);
      zsel     = use_pos ? zero_pos : zero_neg;
      diff     = $signed({mean_val[MEAN_W-1], mean_val}) - $signed({zsel[ZERO_W-1], zsel});
      diff_neg = -diff;
      gsel     = use_pos ? $signed({gain_pos[GAIN_W-1], gain_pos})
                         : -$signed({gain_neg[GAIN_W-1], gain_neg});
   end

   // floor shift to Q1.15 and saturate
   always_comb begin
      prod   = dneg_ff ? -acc_ff : acc_ff;
      shr    = prod[PROD_W-1:FRAC_DROP];
      shr_hi = shr[SH_W-1:SPEED_W-1];
      if (shr_hi != '0 && shr_hi != '1) begin
         speed_sat = shr[SH_W-1] ? {1'b1, {(SPEED_W-1){1'b0}}}
                                 : {1'b0, {(SPEED_W-1){1'b1}}};
      end else begin
         speed_sat = shr[SPEED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         quo_ff   <= sum_mag;
         rem_ff   <= '0;
         dvs_ff   <= cnt_ff;
         neg_ff   <= sum_ff[SUM_W-1];
         empty_ff <= (cnt_ff == '0);
      end else if (ctrl.div_step) begin
         quo_ff <= {quo_ff[SUM_W-2:0], qbit};
         rem_ff <= qbit ? trial[CNT_W-1:0] : rem_shift[CNT_W-1:0];
      end
      if (ctrl.mean_step) begin
         mean_ff   <= mean_val;
         dneg_ff   <= diff[MAG_W];
         mplier_ff <= diff[MAG_W] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
         mcand_ff  <= {{(PROD_W - GAIN_W - 1){gsel[GAIN_W]}}, gsel};
         acc_ff    <= '0;
      end else if (ctrl.mul_step) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff  <= mcand_ff <<< 1;
         mplier_ff <= mplier_ff >> 1;
      end
      if (ctrl.fin_step) begin
         speed_ff <= speed_sat;
      end
   end

   assign mean  = mean_ff;
   assign speed = speed_ff;
   assign empty = empty_ff;

endmodule

@@ hw/rtl/signed_adc_mean_normalizer.sv @@
// Top level of the two-channel signed ADC mean normalizer: sequencer, CSRs, output register.
//
// A sample beat is handled when it is accepted. A tick beat snapshots both channel sums and
// counts, then both channels run in lockstep: a bit-serial restoring divider gives one
// quotient bit per cycle over the 24-bit sum, the mean state saturates the mean
// and picks the calibration side, a shift-add multiplier takes one bit of the 11-bit
// (mean - zero) magnitude per cycle, the finish state scales and saturates the
// speed, and the hold state waits until the output register is free, then loads it.
// No new beat is accepted until the result has moved to the output register, so
// sample beats are not accepted while a result waits in the hold state.
module signed_adc_mean_normalizer import samn_pkg::*; #(
   parameter int SETTLE_SKIP = SETTLE_SKIP_DEF,
   parameter int START_SKIP  = START_SKIP_DEF,
   parameter int COUNT_MAX   = COUNT_MAX_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_op,
   input  logic [SMP_W-1:0]           req_sample,
   input  logic                       req_left_reverse,
   input  logic                       req_right_reverse,
   input  logic                       req_clear_after,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [MEAN_W-1:0]   rsp_left_mean,
   output logic signed [MEAN_W-1:0]   rsp_right_mean,
   output logic signed [SPEED_W-1:0]  rsp_left_speed,
   output logic signed [SPEED_W-1:0]  rsp_right_speed,
   output logic                       rsp_left_empty,
   output logic                       rsp_right_empty,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_MEAN = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;
   localparam logic [2:0] S_HOLD = 3'd5;

   localparam logic [SKIP_W-1:0] SKIP_START  = SKIP_W'(START_SKIP);
   localparam logic [SKIP_W-1:0] SKIP_SETTLE = SKIP_W'(SETTLE_SKIP);
   localparam logic [STEP_W-1:0] DIV_LAST    = STEP_W'(SUM_W - 1);
   localparam logic [STEP_W-1:0] MUL_LAST    = STEP_W'(MAG_W - 1);

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SKIP_W-1:0] skip_ff, skip_in;
   logic              channel_ff, channel_in;

   logic signed [ZERO_W-1:0] left_zero_pos_ff, left_zero_neg_ff;
   logic signed [ZERO_W-1:0] right_zero_pos_ff, right_zero_neg_ff;
   logic signed [GAIN_W-1:0] left_gain_pos_ff, left_gain_neg_ff;
   logic signed [GAIN_W-1:0] right_gain_pos_ff, right_gain_neg_ff;

   logic              req_accept;
   logic              take;
   logic              acc_left, acc_right;
   logic              out_load;
   samn_ctrl_type     ctrl;

   logic signed [MEAN_W-1:0]  left_mean, right_mean;
   logic signed [SPEED_W-1:0] left_speed, right_speed;
   logic                      left_empty, right_empty;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [MEAN_W-1:0]  rsp_left_mean_ff, rsp_right_mean_ff;
   logic signed [SPEED_W-1:0] rsp_left_speed_ff, rsp_right_speed_ff;
   logic                      rsp_left_empty_ff, rsp_right_empty_ff;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign take       = req_accept && (req_op == OP_SAMPLE) && (skip_ff == '0);
   assign acc_left   = take && !channel_ff;
   assign acc_right  = take && channel_ff;
   assign out_load   = (state_ff == S_HOLD) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      ctrl.load      = req_accept && (req_op == OP_TICK);
      ctrl.clear     = req_accept && (req_op == OP_TICK) && req_clear_after;
      ctrl.div_step  = (state_ff == S_DIV);
      ctrl.mean_step = (state_ff == S_MEAN);
      ctrl.mul_step  = (state_ff == S_MUL);
      ctrl.fin_step  = (state_ff == S_FIN);
   end

   // skip pattern and channel alternation
   always_comb begin
      skip_in    = skip_ff;
      channel_in = channel_ff;
      if (req_accept && (req_op == OP_SAMPLE)) begin
         if (take) begin
            skip_in    = SKIP_SETTLE;
            channel_in = !channel_ff;
         end else begin
            skip_in = skip_ff - 1'b1;
         end
      end
   end

   // tick sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            step_in = '0;
            if (ctrl.load) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (step_ff == DIV_LAST) begin
               step_in  = '0;
               state_in = S_MEAN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_MEAN: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            if (step_ff == MUL_LAST) begin
               step_in  = '0;
               state_in = S_FIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_FIN: begin
            state_in = S_HOLD;
         end
         S_HOLD: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            step_in  = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         skip_ff      <= SKIP_START;
         channel_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         skip_ff      <= skip_in;
         channel_ff   <= channel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         left_zero_pos_ff  <= '0;
         left_zero_neg_ff  <= '0;
         right_zero_pos_ff <= '0;
         right_zero_neg_ff <= '0;
         left_gain_pos_ff  <= '0;
         left_gain_neg_ff  <= '0;
         right_gain_pos_ff <= '0;
         right_gain_neg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_LEFT_ZERO_POS:  left_zero_pos_ff  <= csr_wdata[ZERO_W-1:0];
            REG_LEFT_ZERO_NEG:  left_zero_neg_ff  <= csr_wdata[ZERO_W-1:0];
            REG_RIGHT_ZERO_POS: right_zero_pos_ff <= csr_wdata[ZERO_W-1:0];
            REG_RIGHT_ZERO_NEG: right_zero_neg_ff <= csr_wdata[ZERO_W-1:0];
            REG_LEFT_GAIN_POS:  left_gain_pos_ff  <= csr_wdata[GAIN_W-1:0];
            REG_LEFT_GAIN_NEG:  left_gain_neg_ff  <= csr_wdata[GAIN_W-1:0];
            REG_RIGHT_GAIN_POS: right_gain_pos_ff <= csr_wdata[GAIN_W-1:0];
            REG_RIGHT_GAIN_NEG: right_gain_neg_ff <= csr_wdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_left_mean_ff   <= left_mean;
         rsp_right_mean_ff  <= right_mean;
         rsp_left_speed_ff  <= left_speed;
         rsp_right_speed_ff <= right_speed;
         rsp_left_empty_ff  <= left_empty;
         rsp_right_empty_ff <= right_empty;
      end
   end

   samn_channel #(
      .COUNT_MAX (COUNT_MAX)
   ) u_left (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .acc_en   (acc_left),
      .sample   (req_sample),
      .reverse  (req_left_reverse),
      .zero_pos (left_zero_pos_ff),
      .zero_neg (left_zero_neg_ff),
      .gain_pos (left_gain_pos_ff),
      .gain_neg (left_gain_neg_ff),
      .mean     (left_mean),
      .speed    (left_speed),
      .empty    (left_empty)
   );

   samn_channel #(
      .COUNT_MAX (COUNT_MAX)
   ) u_right (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .acc_en   (acc_right),
      .sample   (req_sample),
      .reverse  (req_right_reverse),
      .zero_pos (right_zero_pos_ff),
      .zero_neg (right_zero_neg_ff),
      .gain_pos (right_gain_pos_ff),
      .gain_neg (right_gain_neg_ff),
      .mean     (right_mean),
      .speed    (right_speed),
      .empty    (right_empty)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_mean   = rsp_left_mean_ff;
   assign rsp_right_mean  = rsp_right_mean_ff;
   assign rsp_left_speed  = rsp_left_speed_ff;
   assign rsp_right_speed = rsp_right_speed_ff;
   assign rsp_left_empty  = rsp_left_empty_ff;
   assign rsp_right_empty = rsp_right_empty_ff;

   a_rsp_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_HOLD)
      else $error("result raised outside the hold state");

   a_tick_starts_div: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |=> state_ff == S_DIV && step_ff == '0)
      else $error("tick beat did not start the divider");

   a_take_toggles: assert property (@(posedge clock) disable iff (reset)
      take |=> channel_ff != $past(channel_ff) && skip_ff == SKIP_SETTLE)
      else $error("taken sample did not toggle channel and reload skip");

   a_mul_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL |-> step_ff <= MUL_LAST)
      else $error("multiplier step count overran");

endmodule
